### rtl/isdr_pkg.sv
// ----------------------------------------------------------------------------
// isdr_pkg
// Shared types and constants for the instance slot table with dirty ranges.
// ----------------------------------------------------------------------------
package isdr_pkg;

    localparam int MAX_SLOTS    = 128;
    localparam int PAYLOAD_BITS = 64;

    // Slot index width and a counter width that can also hold MAX_SLOTS.
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;

    // Operation codes of a request.
    localparam logic [2:0] OP_BEGIN_SYNC = 3'd0;
    localparam logic [2:0] OP_UPSERT     = 3'd1;
    localparam logic [2:0] OP_REMOVE     = 3'd2;
    localparam logic [2:0] OP_END_SYNC   = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    localparam logic [31:0] INVALID_PRIM = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] primitive_id;
        logic [31:0] submesh_index;
        logic [63:0] payload;
        logic        force_dirty;
        logic [31:0] frame_number;
    } in_req_t;

    typedef struct packed {
        logic [6:0] instance_id;
        logic       id_valid;
        logic [6:0] range_start;
        logic [7:0] range_count;
        logic [7:0] dirty_total;
        logic       last;
    } out_rsp_t;

    // One entry of the key and payload memory.
    typedef struct packed {
        logic [31:0]             prim;
        logic [31:0]             sub;
        logic [PAYLOAD_BITS-1:0] data;
    } key_ent_t;

endpackage

### rtl/isdr_ram.sv
// ----------------------------------------------------------------------------
// isdr_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module isdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### rtl/instance_slot_table_dirty_ranges_top.sv
// ----------------------------------------------------------------------------
// instance_slot_table_dirty_ranges_top
// Keyed slot table that tracks changed slots and reports them as runs.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_req (op, key, payload, flags)
//   m_        out        m_valid/m_ready    m_rsp (id, dirty run, total, last)
//
// One request is worked on at a time; s_ready is high only while idle.
// An upsert scans the key memory one slot per cycle through its registered
// read port until a hit stops the scan; the longest case is a miss that
// reuses a freed slot, which also passes through the pop state.
// Remove primitive always scans all MAX_SLOTS slots.
// End sync walks the dirty flags one slot per cycle, except while a closed
// run waits for the output register to be freed by m_ready.
// Begin sync, clear, unused codes and a remove of INVALID_PRIM finish in the cycle of acceptance.
// Reset (synchronous, aresetn low) needs no clearing pass: live and dirty
// flags are flip-flops, and the memories are only read for live slots.
// ----------------------------------------------------------------------------
module instance_slot_table_dirty_ranges_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  isdr_pkg::in_req_t  s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output isdr_pkg::out_rsp_t m_rsp
);

    import isdr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_POP,
        ST_REMOVE,
        ST_RANGES,
        ST_RESP
    } state_t;

    state_t               state_reg;
    in_req_t              req_reg;
    out_rsp_t             rsp_reg;
    out_rsp_t             m_rsp_reg;
    logic                 m_valid_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic                 pend_reg;
    logic [SLOT_W-1:0]    pidx_reg;
    logic [MAX_SLOTS-1:0] live_reg;
    logic [MAX_SLOTS-1:0] dirty_reg;
    logic [CNT_W-1:0]     dirty_cnt_reg;
    logic [CNT_W-1:0]     free_depth_reg;
    logic [CNT_W-1:0]     fresh_reg;
    logic [31:0]          frame_reg;
    logic                 in_run_reg;
    logic [CNT_W-1:0]     start_reg;
    logic [CNT_W-1:0]     seen_reg;

    // Memory ports.
    key_ent_t          ent_rd;
    key_ent_t          ent_wr;
    logic              key_we;
    logic [SLOT_W-1:0] key_waddr;
    logic [SLOT_W-1:0] stk_rdata;
    logic [SLOT_W-1:0] stk_raddr;

    // Scan decisions.
    logic                  scan_end;
    logic [PAYLOAD_BITS-1:0] pay;
    logic                  prim_match;
    logic                  full_match;
    logic                  changed;
    logic                  fresh_avail;
    logic                  lk_hit;
    logic                  lk_miss;
    logic                  out_free;
    logic                  run_bit;
    logic                  rsp_load;
    logic [SLOT_W-1:0]     scan_idx;

    assign scan_idx    = scan_reg[SLOT_W-1:0];
    assign scan_end    = (scan_reg == CNT_W'(MAX_SLOTS));
    assign pay         = req_reg.payload[PAYLOAD_BITS-1:0];
    assign prim_match  = live_reg[pidx_reg] && (ent_rd.prim == req_reg.primitive_id);
    assign full_match  = prim_match && (ent_rd.sub == req_reg.submesh_index);
    assign changed     = req_reg.force_dirty || (ent_rd.data != pay);
    assign fresh_avail = (fresh_reg < CNT_W'(MAX_SLOTS));
    assign lk_hit      = (state_reg == ST_LOOKUP) && pend_reg && full_match;
    assign lk_miss     = (state_reg == ST_LOOKUP) && !pend_reg && scan_end;
    assign out_free    = !m_valid_reg || m_ready;
    assign run_bit     = !scan_end && dirty_reg[scan_idx];
    assign stk_raddr   = SLOT_W'(free_depth_reg - CNT_W'(1));

    // The output register takes a new result from the response state or when
    // a dirty run closes.
    assign rsp_load    = out_free && ((state_reg == ST_RESP) ||
                         ((state_reg == ST_RANGES) && !run_bit && in_run_reg));

    assign ent_wr.prim = req_reg.primitive_id;
    assign ent_wr.sub  = req_reg.submesh_index;
    assign ent_wr.data = pay;

    // Key memory writes: a changed hit, a miss that takes a fresh slot, or a
    // miss that takes the slot popped from the free stack.
    always_comb begin
        key_we    = 1'b0;
        key_waddr = pidx_reg;
        if (lk_hit && changed) begin
            key_we = 1'b1;
        end else if (lk_miss && free_depth_reg == '0 && fresh_avail) begin
            key_we    = 1'b1;
            key_waddr = fresh_reg[SLOT_W-1:0];
        end else if (state_reg == ST_POP) begin
            key_we    = 1'b1;
            key_waddr = stk_rdata;
        end
    end

    isdr_ram #(
        .WIDTH ($bits(key_ent_t)),
        .DEPTH (MAX_SLOTS)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (ent_wr),
        .raddr (scan_idx),
        .rdata (ent_rd)
    );

    // Free stack: pushed during removal, read at the top while a lookup runs
    // so that the popped slot is ready in the cycle after a miss.
    isdr_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    ((state_reg == ST_REMOVE) && pend_reg && prim_match &&
                (free_depth_reg < CNT_W'(MAX_SLOTS))),
        .waddr (free_depth_reg[SLOT_W-1:0]),
        .wdata (pidx_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            pend_reg       <= 1'b0;
            live_reg       <= '0;
            dirty_reg      <= '0;
            dirty_cnt_reg  <= '0;
            free_depth_reg <= '0;
            fresh_reg      <= '0;
            frame_reg      <= '0;
            in_run_reg     <= 1'b0;
        end else begin
            if (rsp_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg  <= s_req;
                        scan_reg <= '0;
                        pend_reg <= 1'b0;
                        // Every result sent from the response state is the
                        // last of its request.
                        rsp_reg  <= '{instance_id: '0, id_valid: 1'b0,
                                      range_start: '0, range_count: '0,
                                      dirty_total: '0, last: 1'b1};
                        unique case (s_req.op)
                            OP_BEGIN_SYNC: begin
                                frame_reg     <= s_req.frame_number;
                                dirty_reg     <= '0;
                                dirty_cnt_reg <= '0;
                            end
                            OP_UPSERT: begin
                                if (s_req.primitive_id == INVALID_PRIM) begin
                                    state_reg <= ST_RESP;
                                end else begin
                                    state_reg <= ST_LOOKUP;
                                end
                            end
                            OP_REMOVE: begin
                                if (s_req.primitive_id != INVALID_PRIM) begin
                                    state_reg <= ST_REMOVE;
                                end
                            end
                            OP_END_SYNC: begin
                                if (dirty_cnt_reg == '0) begin
                                    state_reg <= ST_RESP;
                                end else begin
                                    in_run_reg <= 1'b0;
                                    seen_reg   <= '0;
                                    state_reg  <= ST_RANGES;
                                end
                            end
                            OP_CLEAR: begin
                                live_reg       <= '0;
                                dirty_reg      <= '0;
                                dirty_cnt_reg  <= '0;
                                free_depth_reg <= '0;
                                fresh_reg      <= '0;
                                frame_reg      <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end

                ST_LOOKUP: begin
                    pend_reg <= !scan_end;
                    pidx_reg <= scan_idx;
                    if (!scan_end) begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                    if (lk_hit) begin
                        if (changed) begin
                            dirty_reg[pidx_reg] <= 1'b1;
                            if (!dirty_reg[pidx_reg]) begin
                                dirty_cnt_reg <= dirty_cnt_reg + CNT_W'(1);
                            end
                        end
                        rsp_reg.instance_id <= 7'(pidx_reg);
                        rsp_reg.id_valid    <= 1'b1;
                        state_reg           <= ST_RESP;
                    end else if (lk_miss) begin
                        if (free_depth_reg != '0) begin
                            free_depth_reg <= free_depth_reg - CNT_W'(1);
                            state_reg      <= ST_POP;
                        end else if (fresh_avail) begin
                            live_reg[fresh_reg[SLOT_W-1:0]]  <= 1'b1;
                            dirty_reg[fresh_reg[SLOT_W-1:0]] <= 1'b1;
                            if (!dirty_reg[fresh_reg[SLOT_W-1:0]]) begin
                                dirty_cnt_reg <= dirty_cnt_reg + CNT_W'(1);
                            end
                            fresh_reg           <= fresh_reg + CNT_W'(1);
                            rsp_reg.instance_id <= 7'(fresh_reg[SLOT_W-1:0]);
                            rsp_reg.id_valid    <= 1'b1;
                            state_reg           <= ST_RESP;
                        end else begin
                            state_reg <= ST_RESP;
                        end
                    end
                end

                ST_POP: begin
                    live_reg[stk_rdata]  <= 1'b1;
                    dirty_reg[stk_rdata] <= 1'b1;
                    if (!dirty_reg[stk_rdata]) begin
                        dirty_cnt_reg <= dirty_cnt_reg + CNT_W'(1);
                    end
                    rsp_reg.instance_id <= 7'(stk_rdata);
                    rsp_reg.id_valid    <= 1'b1;
                    state_reg           <= ST_RESP;
                end

                ST_REMOVE: begin
                    pend_reg <= !scan_end;
                    pidx_reg <= scan_idx;
                    if (!scan_end) begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                    if (pend_reg && prim_match) begin
                        live_reg[pidx_reg]  <= 1'b0;
                        dirty_reg[pidx_reg] <= 1'b1;
                        if (!dirty_reg[pidx_reg]) begin
                            dirty_cnt_reg <= dirty_cnt_reg + CNT_W'(1);
                        end
                        if (free_depth_reg < CNT_W'(MAX_SLOTS)) begin
                            free_depth_reg <= free_depth_reg + CNT_W'(1);
                        end
                    end
                    if (!pend_reg && scan_end) begin
                        state_reg <= ST_IDLE;
                    end
                end

                ST_RANGES: begin
                    // A run closes on the first clean slot after it or at the table end; the
                    // last run is the one that accounts for every dirty slot.
                    if (run_bit) begin
                        if (!in_run_reg) begin
                            start_reg  <= scan_reg;
                            in_run_reg <= 1'b1;
                        end
                        seen_reg <= seen_reg + CNT_W'(1);
                        scan_reg <= scan_reg + CNT_W'(1);
                    end else if (in_run_reg) begin
                        if (out_free) begin
                            m_rsp_reg  <= '{instance_id: '0, id_valid: 1'b0,
                                           range_start: 7'(start_reg[SLOT_W-1:0]),
                                           range_count: 8'(scan_reg - start_reg),
                                           dirty_total: 8'(dirty_cnt_reg),
                                           last: (seen_reg == dirty_cnt_reg)};
                            in_run_reg <= 1'b0;
                            if (seen_reg == dirty_cnt_reg) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                scan_reg <= scan_reg + CNT_W'(1);
                            end
                        end
                    end else if (scan_end) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end

                ST_RESP: begin
                    if (out_free) begin
                        m_rsp_reg <= rsp_reg;
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // The running dirty count always agrees with the dirty flags.
    a_dirty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        dirty_cnt_reg == CNT_W'($countones(dirty_reg)))
        else $error("dirty count out of step with dirty flags");

    // Every slot ever handed out is either live or waiting on the free stack.
    a_slot_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |->
        (CNT_W'($countones(live_reg)) + free_depth_reg == fresh_reg))
        else $error("live slots and free stack do not add up");

    // A result is never overwritten while it is still held by the consumer.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_rsp_reg)))
        else $error("pending result lost");

    // Nothing is taken from the free stack when it is empty.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POP) |-> (free_depth_reg < fresh_reg))
        else $error("pop from an empty free stack");

endmodule

### tb/tb_instance_slot_table_dirty_ranges_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_instance_slot_table_dirty_ranges_top
// Self-checking bench for the keyed slot table: a table model predicts the
// slot ids of upserts and the dirty runs of end sync, and a monitor checks
// every response in order, field by field, while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_instance_slot_table_dirty_ranges_top;
    import isdr_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_req = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_rsp_t m_rsp;

    instance_slot_table_dirty_ranges_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
    );

    always #5 aclk = ~aclk;

    // Requests still to be sent, and responses that the table model predicts.
    in_req_t  pending_reqs[$];
    out_rsp_t expected_rsps[$];
    int       error_count = 0;

    // Idle rates in percent, changed between phases; a hold flag lets the
    // sender stop until every predicted response has come back.
    int  send_idle_pct = 25;
    int  recv_idle_pct = 50;
    bit  send_hold = 1'b0;

    // The bench's own copy of the table.
    logic [31:0] tbl_prim[MAX_SLOTS];
    logic [31:0] tbl_sub[MAX_SLOTS];
    logic [63:0] tbl_data[MAX_SLOTS];
    bit          tbl_live[MAX_SLOTS];
    bit          tbl_dirty[MAX_SLOTS];
    logic [6:0]  free_slots[$];
    int          fresh_slot;
    logic [31:0] frame_seen;

    // Keys of earlier upserts, so that random upserts can hit existing slots.
    logic [31:0] known_prims[$];

    function automatic out_rsp_t make_rsp(int id, bit vld, int start, int cnt,
                                          int total, bit fin);
        out_rsp_t r;
        r.instance_id = id[6:0];
        r.id_valid    = vld;
        r.range_start = start[6:0];
        r.range_count = cnt[7:0];
        r.dirty_total = total[7:0];
        r.last        = fin;
        return r;
    endfunction

    function automatic void queue_req(in_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic void expect_rsp(out_rsp_t r);
        expected_rsps.insert(expected_rsps.size(), r);
    endfunction

    task automatic table_reset();
        for (int i = 0; i < MAX_SLOTS; i++) begin
            tbl_live[i]  = 1'b0;
            tbl_dirty[i] = 1'b0;
        end
        free_slots.delete();
        fresh_slot = 0;
        frame_seen = '0;
    endtask

    // Applies one accepted request to the table copy and queues its responses.
    task automatic predict_table(in_req_t rq);
        int slot;
        int total;
        int start;
        bit hit;
        slot = 0;
        total = 0;
        start = 0;
        hit = 1'b0;
        case (rq.op)
            OP_BEGIN_SYNC: begin
                frame_seen = rq.frame_number;
                for (int i = 0; i < MAX_SLOTS; i++) tbl_dirty[i] = 1'b0;
            end
            OP_UPSERT: begin
                if (rq.primitive_id == INVALID_PRIM) begin
                    expect_rsp(make_rsp(0, 0, 0, 0, 0, 1));
                end else begin
                    for (int i = 0; i < MAX_SLOTS && !hit; i++) begin
                        if (tbl_live[i] && tbl_prim[i] == rq.primitive_id &&
                            tbl_sub[i] == rq.submesh_index) begin
                            hit = 1'b1;
                            slot = i;
                        end
                    end
                    if (hit) begin
                        if (rq.force_dirty || tbl_data[slot] != rq.payload) begin
                            tbl_data[slot]  = rq.payload;
                            tbl_dirty[slot] = 1'b1;
                        end
                        expect_rsp(make_rsp(slot, 1, 0, 0, 0, 1));
                    end else if (free_slots.size() > 0 || fresh_slot < MAX_SLOTS) begin
                        if (free_slots.size() > 0) begin
                            slot = free_slots[free_slots.size() - 1];
                            free_slots.delete(free_slots.size() - 1);
                        end else begin
                            slot = fresh_slot;
                            fresh_slot++;
                        end
                        tbl_prim[slot]  = rq.primitive_id;
                        tbl_sub[slot]   = rq.submesh_index;
                        tbl_data[slot]  = rq.payload;
                        tbl_live[slot]  = 1'b1;
                        tbl_dirty[slot] = 1'b1;
                        expect_rsp(make_rsp(slot, 1, 0, 0, 0, 1));
                    end else begin
                        expect_rsp(make_rsp(0, 0, 0, 0, 0, 1));
                    end
                end
            end
            OP_REMOVE: begin
                if (rq.primitive_id != INVALID_PRIM) begin
                    for (int i = 0; i < MAX_SLOTS; i++) begin
                        if (tbl_live[i] && tbl_prim[i] == rq.primitive_id) begin
                            tbl_live[i]  = 1'b0;
                            tbl_dirty[i] = 1'b1;
                            free_slots.insert(free_slots.size(), i[6:0]);
                        end
                    end
                end
            end
            OP_END_SYNC: begin
                for (int i = 0; i < MAX_SLOTS; i++) total += tbl_dirty[i];
                if (total == 0) begin
                    expect_rsp(make_rsp(0, 0, 0, 0, 0, 1));
                end else begin
                    for (int i = 0; i <= MAX_SLOTS; i++) begin
                        if (i < MAX_SLOTS && tbl_dirty[i]) begin
                            if (i == 0 || !tbl_dirty[i-1]) start = i;
                        end else if (i > 0 && tbl_dirty[i-1]) begin
                            expect_rsp(make_rsp(0, 0, start, i - start, total, 0));
                        end
                    end
                    expected_rsps[$].last = 1'b1;
                end
            end
            OP_CLEAR: table_reset();
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Driver: a request is held until accepted, then the next one may follow.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_table(s_req);
            if (!(s_valid && !s_ready)) begin
                if (pending_reqs.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_req   <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: each response is compared with the oldest prediction.
    always @(posedge aclk) begin
        out_rsp_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("unpredicted response count", 1, 0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (m_rsp.instance_id != want.instance_id)
                        report_mismatch("instance_id", m_rsp.instance_id, want.instance_id);
                    if (m_rsp.id_valid != want.id_valid)
                        report_mismatch("id_valid", m_rsp.id_valid, want.id_valid);
                    if (m_rsp.range_start != want.range_start)
                        report_mismatch("range_start", m_rsp.range_start, want.range_start);
                    if (m_rsp.range_count != want.range_count)
                        report_mismatch("range_count", m_rsp.range_count, want.range_count);
                    if (m_rsp.dirty_total != want.dirty_total)
                        report_mismatch("dirty_total", m_rsp.dirty_total, want.dirty_total);
                    if (m_rsp.last != want.last)
                        report_mismatch("last", m_rsp.last, want.last);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic in_req_t build_req(logic [2:0] op, logic [31:0] prim,
                                          logic [31:0] sub, logic [63:0] data,
                                          int force_it);
        in_req_t r;
        r.op            = op;
        r.primitive_id  = prim;
        r.submesh_index = sub;
        r.payload       = data;
        r.force_dirty   = (force_it != 0);
        r.frame_number  = $urandom();
        return r;
    endfunction

    // Waits for the sender to drain and for every prediction to be met.
    task automatic drain_all();
        while (pending_reqs.size() > 0 || s_valid || expected_rsps.size() > 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    // One frame of random traffic: mostly upserts on a small key set so that
    // hits, changed payloads, removals and slot reuse are common.
    task automatic queue_frame(int n_ops);
        logic [31:0] prim;
        int pick;
        queue_req(build_req(OP_BEGIN_SYNC, $urandom(), 0, 0, 0));
        for (int k = 0; k < n_ops; k++) begin
            pick = $urandom_range(99);
            prim = (known_prims.size() > 0 && $urandom_range(1))
                   ? known_prims[$urandom_range(known_prims.size() - 1)]
                   : $urandom_range(12);
            if ($urandom_range(40) == 0) prim = INVALID_PRIM;
            else if ($urandom_range(40) == 0) prim = $urandom();
            if (pick < 70) begin
                queue_req(build_req(OP_UPSERT, prim, $urandom_range(3),
                    $urandom_range(3) == 0 ? {$urandom(), $urandom()} : 64'($urandom_range(2)),
                    $urandom_range(1)));
                known_prims.insert(known_prims.size(), prim);
            end else if (pick < 85) begin
                queue_req(build_req(OP_REMOVE, prim, $urandom(), 0, 0));
            end else if (pick < 95) begin
                queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
            end else if (pick < 98) begin
                queue_req(build_req(3'($urandom_range(5, 7)), $urandom(),
                                    $urandom(), 0, 0));
            end else begin
                queue_req(build_req(OP_CLEAR, 0, 0, 0, 0));
            end
        end
        queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
    endtask

    initial begin
        table_reset();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty end sync, extreme fields, hit with and without
        // change, forced dirty, invalid primitive, removal and stack reuse,
        // unused codes and clear.
        queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
        queue_req(build_req(OP_BEGIN_SYNC, 0, 0, 0, 0));
        queue_req(build_req(OP_UPSERT, 0, 0, 0, 0));
        queue_req(build_req(OP_UPSERT, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                            64'hFFFF_FFFF_FFFF_FFFF, 1));
        queue_req(build_req(OP_UPSERT, 5, 1, 64'h1234, 0));
        queue_req(build_req(OP_UPSERT, 5, 2, 64'h5678, 0));
        queue_req(build_req(OP_UPSERT, INVALID_PRIM, 0, 1, 1));
        queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
        queue_req(build_req(OP_BEGIN_SYNC, 32'hFFFF_FFFF, 0, 0, 0));
        queue_req(build_req(OP_UPSERT, 0, 0, 0, 0));
        queue_req(build_req(OP_UPSERT, 5, 1, 64'h1234, 1));
        queue_req(build_req(OP_UPSERT, 5, 2, 64'h9999, 0));
        queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
        queue_req(build_req(OP_REMOVE, 5, 0, 0, 0));
        queue_req(build_req(OP_REMOVE, INVALID_PRIM, 0, 0, 0));
        queue_req(build_req(OP_UPSERT, 7, 0, 64'h1, 0));
        queue_req(build_req(OP_UPSERT, 7, 1, 64'h2, 0));
        queue_req(build_req(3'd5, 0, 0, 0, 0));
        queue_req(build_req(3'd7, 0, 0, 0, 0));
        queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
        queue_req(build_req(OP_CLEAR, 0, 0, 0, 0));
        queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
        drain_all();

        // Fill the table to the brim and try one more key, then report the
        // single full-length run and free it all again.
        queue_req(build_req(OP_BEGIN_SYNC, 0, 0, 0, 0));
        for (int i = 0; i <= MAX_SLOTS; i++)
            queue_req(build_req(OP_UPSERT, 100 + i % 3, i, $urandom(), 0));
        queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
        queue_req(build_req(OP_REMOVE, 101, 0, 0, 0));
        queue_req(build_req(OP_END_SYNC, 0, 0, 0, 0));
        queue_req(build_req(OP_CLEAR, 0, 0, 0, 0));
        drain_all();

        // Random frames under three idle patterns, with one full pause of the
        // sender in the middle of each pattern.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 25 : 0;
            for (int f = 0; f < 4; f++) begin
                queue_frame($urandom_range(6, 16));
                if (f == 2) begin
                    while (pending_reqs.size() > 0 || s_valid) @(posedge aclk);
                    send_hold = 1'b1;
                    while (expected_rsps.size() > 0) @(posedge aclk);
                    send_hold = 1'b0;
                end
            end
            drain_all();
        end

        if (error_count == 0)
            $display("tb_instance_slot_table_dirty_ranges_top: done, clean");
        else
            $display("tb_instance_slot_table_dirty_ranges_top: done, errors");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("tb_instance_slot_table_dirty_ranges_top: done, errors");
        $finish;
    end

endmodule

### instance_slot_table_dirty_ranges_top.f
rtl/isdr_pkg.sv
rtl/isdr_ram.sv
rtl/instance_slot_table_dirty_ranges_top.sv
tb/tb_instance_slot_table_dirty_ranges_top.sv
